### hdl/tlca_pkg.sv
package tlca_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_NODES_DEF  = 1024;
    localparam int LOG_LEVELS_DEF = 10;

    // Fixed field widths
    localparam int OP_W       = 2;
    localparam int NODE_FIELD_W = 10;
    localparam int DEPTH_W    = 10;
    localparam int STAMP_W    = 12;

    // Stream word widths
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = OP_W;
    localparam int M_TDATA_W = 4 * NODE_FIELD_W;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

    typedef enum logic [OP_W-1:0] {
        OP_ENTER = 2'd0,
        OP_LEAVE = 2'd1,
        OP_QUERY = 2'd2
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NORM_MUL,
        ST_NORM_SUB,
        ST_ENT_LEVEL,
        ST_QRY_A,
        ST_QRY_B,
        ST_LIFT_UP,
        ST_LIFT_CMP,
        ST_FIN_J,
        ST_FIN_D,
        ST_QRY_OUT
    } state_t;

    typedef struct packed {
        logic [STAMP_W-1:0] entry_stamp;
        logic [STAMP_W-1:0] exit_stamp;
        logic [DEPTH_W-1:0] depth;
    } node_info_t;

endpackage

### hdl/tree_lca_binary_lifting.sv
// Leave item: the word passes ST_NORM_MUL and ST_NORM_SUB, where the exit stamp is written.
// Enter item: after normalisation, one jump-table level is filled per cycle in ST_ENT_LEVEL.
// Query item: when one node contains the other, the result follows the two node reads;
// else a lifting walk runs: each level needs a jump read and a dependent node read.
// One item is in work at a time; a finished result waits in the output register.
// Reset (aresetn low, synchronous) clears the visit clock and control; tables hold garbage.
module tree_lca_binary_lifting #(
    parameter int MAX_NODES  = tlca_pkg::MAX_NODES_DEF,
    parameter int LOG_LEVELS = tlca_pkg::LOG_LEVELS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata: [9:0] node_a, [19:10] node_b, [23:20] zero
    input  logic [tlca_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: [1:0] opcode
    input  logic [tlca_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // m_tdata: [9:0] ancestor_node, [19:10] ancestor_depth,
    //          [29:20] depth_first, [39:30] depth_second
    output logic [tlca_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready
);
    import tlca_pkg::*;

    // Table geometry: the jump table is addressed as {node, level}
    localparam int NODE_W     = $clog2(MAX_NODES);
    localparam int LVL_W      = $clog2(LOG_LEVELS + 1);
    localparam int JUMP_AW    = NODE_W + LVL_W;
    localparam int JUMP_DEPTH = MAX_NODES << LVL_W;
    localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(LOG_LEVELS);

    // Node number reduction modulo MAX_NODES by reciprocal multiply;
    // the estimated quotient is at most one low, so one correction step follows.
    localparam int NORM_SHIFT = 20;
    localparam int NORM_RECIP = (1 << NORM_SHIFT) / MAX_NODES;
    localparam int PROD_W     = NODE_FIELD_W + NORM_SHIFT;
    localparam int MUL_W      = NODE_FIELD_W + $clog2(MAX_NODES + 1);
    localparam int REM_W      = NODE_FIELD_W + 1;

    function automatic logic [NODE_W-1:0] node_reduce(
        input logic [NODE_FIELD_W-1:0] raw,
        input logic [PROD_W-1:0]       prod
    );
        logic [NODE_FIELD_W-1:0] quot;
        logic [MUL_W-1:0]        qm;
        logic [REM_W-1:0]        rem;
        quot = prod[PROD_W-1 -: NODE_FIELD_W];
        qm   = MUL_W'(quot) * MUL_W'(MAX_NODES);
        rem  = REM_W'(raw) - qm[REM_W-1:0];
        if (32'(rem) >= MAX_NODES) begin
            rem = rem - REM_W'(MAX_NODES);
        end
        return NODE_W'(rem);
    endfunction

    // up contains down in the visit order
    function automatic logic node_contains(input node_info_t up, input node_info_t down);
        return (up.entry_stamp <= down.entry_stamp) && (up.exit_stamp >= down.exit_stamp);
    endfunction

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    state_t                  state_reg, state_next;
    logic [OP_W-1:0]         op_reg, op_next;
    logic [NODE_FIELD_W-1:0] raw_a_reg, raw_a_next;
    logic [NODE_FIELD_W-1:0] raw_b_reg, raw_b_next;
    logic [PROD_W-1:0]       prod_a_reg, prod_a_next;
    logic [PROD_W-1:0]       prod_b_reg, prod_b_next;
    logic [NODE_W-1:0]       cur_reg, cur_next;      // entered node, or node being lifted
    logic [NODE_W-1:0]       nb_reg, nb_next;        // parent, or second query node
    logic [NODE_W-1:0]       up_reg, up_next;        // candidate ancestor while lifting
    logic [LVL_W-1:0]        lvl_reg, lvl_next;
    logic [STAMP_W-1:0]      clock_reg, clock_next;
    node_info_t              info_a_reg, info_a_next;
    node_info_t              info_b_reg, info_b_next;
    logic [NODE_W-1:0]       res_anc_reg, res_anc_next;
    logic [DEPTH_W-1:0]      res_dep_reg, res_dep_next;
    logic [NODE_FIELD_W-1:0] out_anc_reg, out_anc_next;
    logic [DEPTH_W-1:0]      out_dep_reg, out_dep_next;
    logic [DEPTH_W-1:0]      out_first_reg, out_first_next;
    logic [DEPTH_W-1:0]      out_second_reg, out_second_next;
    logic                    m_tvalid_reg, m_tvalid_next;

    // ---------------------------------------------------------------
    // Memories: node info (stamps, depth) and jump table
    // ---------------------------------------------------------------
    node_info_t        node_mem [MAX_NODES];
    logic [NODE_W-1:0] jump_mem [JUMP_DEPTH];

    logic              n_re;
    logic [NODE_W-1:0] n_raddr;
    logic              n_we_entry;    // writes entry stamp and depth
    logic              n_we_exit;
    logic [NODE_W-1:0] n_waddr;
    node_info_t        n_wdata;
    node_info_t        n_q_reg;
    node_info_t        n_rdata;

    logic               j_re;
    logic [JUMP_AW-1:0] j_raddr;
    logic               j_we;
    logic [JUMP_AW-1:0] j_waddr;
    logic [NODE_W-1:0]  j_wdata;
    logic [NODE_W-1:0]  j_q_reg;
    logic               j_fwd_reg;
    logic [NODE_W-1:0]  j_fwd_data_reg;
    logic [NODE_W-1:0]  j_rdata;

    always_ff @(posedge aclk) begin
        if (n_we_entry) begin
            node_mem[n_waddr].entry_stamp <= n_wdata.entry_stamp;
            node_mem[n_waddr].depth       <= n_wdata.depth;
        end
        if (n_we_exit) begin
            node_mem[n_waddr].exit_stamp <= n_wdata.exit_stamp;
        end
        if (n_re) begin
            n_q_reg <= node_mem[n_raddr];
        end
    end

    assign n_rdata = n_q_reg;

    // A level read in the same cycle as the write of that level (root enter)
    // must see the new value: forward the write data.
    always_ff @(posedge aclk) begin
        if (j_we) begin
            jump_mem[j_waddr] <= j_wdata;
        end
        if (j_re) begin
            j_q_reg        <= jump_mem[j_raddr];
            j_fwd_reg      <= j_we && (j_waddr == j_raddr);
            j_fwd_data_reg <= j_wdata;
        end
    end

    assign j_rdata = j_fwd_reg ? j_fwd_data_reg : j_q_reg;

    // ---------------------------------------------------------------
    // Shared decisions
    // ---------------------------------------------------------------
    logic              out_free;
    logic              a_has_b;
    logic              b_has_a;
    logic              up_has_b;
    logic [NODE_W-1:0] lift_node;
    logic [NODE_W-1:0] norm_a;
    logic [NODE_W-1:0] norm_b;
    logic [STAMP_W-1:0] clock_inc;
    logic [DEPTH_W-1:0] child_depth;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign a_has_b   = node_contains(info_a_reg, n_rdata);   // n_rdata holds node b
    assign b_has_a   = node_contains(n_rdata, info_a_reg);
    assign up_has_b  = node_contains(n_rdata, info_b_reg);   // n_rdata holds candidate
    assign lift_node = up_has_b ? cur_reg : up_reg;
    assign norm_a    = node_reduce(raw_a_reg, prod_a_reg);
    assign norm_b    = node_reduce(raw_b_reg, prod_b_reg);
    assign clock_inc = clock_reg + STAMP_W'(1);

    // Root sits at depth zero; a child saturates at the top depth
    always_comb begin
        if (cur_reg == nb_reg) begin
            child_depth = '0;
        end else if (n_rdata.depth == DEPTH_MAX) begin
            child_depth = DEPTH_MAX;
        end else begin
            child_depth = n_rdata.depth + DEPTH_W'(1);
        end
    end

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_NORM_MUL;
                end
            end
            ST_NORM_MUL: state_next = ST_NORM_SUB;
            ST_NORM_SUB: begin
                case (op_reg)
                    OP_ENTER: state_next = ST_ENT_LEVEL;
                    OP_QUERY: state_next = ST_QRY_A;
                    default:  state_next = ST_IDLE;
                endcase
            end
            ST_ENT_LEVEL: begin
                if (lvl_reg == LVL_TOP) begin
                    state_next = ST_IDLE;
                end
            end
            ST_QRY_A: state_next = ST_QRY_B;
            ST_QRY_B: begin
                if (a_has_b || b_has_a) begin
                    state_next = ST_QRY_OUT;
                end else begin
                    state_next = ST_LIFT_UP;
                end
            end
            ST_LIFT_UP: state_next = ST_LIFT_CMP;
            ST_LIFT_CMP: begin
                if (lvl_reg == '0) begin
                    state_next = ST_FIN_J;
                end else begin
                    state_next = ST_LIFT_UP;
                end
            end
            ST_FIN_J: state_next = ST_FIN_D;
            ST_FIN_D: state_next = ST_QRY_OUT;
            ST_QRY_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Outputs: memory controls and datapath updates
    // ---------------------------------------------------------------
    always_comb begin
        s_tready        = 1'b0;
        op_next         = op_reg;
        raw_a_next      = raw_a_reg;
        raw_b_next      = raw_b_reg;
        prod_a_next     = prod_a_reg;
        prod_b_next     = prod_b_reg;
        cur_next        = cur_reg;
        nb_next         = nb_reg;
        up_next         = up_reg;
        lvl_next        = lvl_reg;
        clock_next      = clock_reg;
        info_a_next     = info_a_reg;
        info_b_next     = info_b_reg;
        res_anc_next    = res_anc_reg;
        res_dep_next    = res_dep_reg;
        out_anc_next    = out_anc_reg;
        out_dep_next    = out_dep_reg;
        out_first_next  = out_first_reg;
        out_second_next = out_second_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;

        n_re       = 1'b0;
        n_raddr    = nb_reg;
        n_we_entry = 1'b0;
        n_we_exit  = 1'b0;
        n_waddr    = cur_reg;
        n_wdata    = '{entry_stamp: clock_reg, exit_stamp: clock_reg, depth: child_depth};
        j_re       = 1'b0;
        j_raddr    = {cur_reg, lvl_reg};
        j_we       = 1'b0;
        j_waddr    = {cur_reg, lvl_reg};
        j_wdata    = j_rdata;

        case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                op_next    = s_tuser;
                raw_a_next = s_tdata[NODE_FIELD_W-1:0];
                raw_b_next = s_tdata[2*NODE_FIELD_W-1:NODE_FIELD_W];
            end
            ST_NORM_MUL: begin
                prod_a_next = PROD_W'(raw_a_reg) * PROD_W'(NORM_RECIP);
                prod_b_next = PROD_W'(raw_b_reg) * PROD_W'(NORM_RECIP);
            end
            ST_NORM_SUB: begin
                cur_next = norm_a;
                nb_next  = norm_b;
                case (op_reg)
                    OP_ENTER: begin
                        // level 0 is the parent; fetch the parent's depth and level 0
                        clock_next = clock_inc;
                        j_we       = 1'b1;
                        j_waddr    = {norm_a, {LVL_W{1'b0}}};
                        j_wdata    = norm_b;
                        j_re       = 1'b1;
                        j_raddr    = {norm_b, {LVL_W{1'b0}}};
                        n_re       = 1'b1;
                        n_raddr    = norm_b;
                        lvl_next   = LVL_W'(1);
                    end
                    OP_LEAVE: begin
                        clock_next = clock_inc;
                        n_we_exit  = 1'b1;
                        n_waddr    = norm_a;
                        n_wdata.exit_stamp = clock_inc;
                    end
                    OP_QUERY: begin
                        n_re    = 1'b1;
                        n_raddr = norm_a;
                    end
                    default: begin
                        // unknown opcode: drop the word
                    end
                endcase
            end
            ST_ENT_LEVEL: begin
                // j_rdata is this level's ancestor; it also keys the next level
                j_we = 1'b1;
                if (lvl_reg == LVL_W'(1)) begin
                    n_we_entry = 1'b1;
                end
                if (lvl_reg != LVL_TOP) begin
                    j_re     = 1'b1;
                    j_raddr  = {j_rdata, lvl_reg};
                    lvl_next = lvl_reg + LVL_W'(1);
                end
            end
            ST_QRY_A: begin
                info_a_next = n_rdata;
                n_re        = 1'b1;
                n_raddr     = nb_reg;
            end
            ST_QRY_B: begin
                info_b_next = n_rdata;
                if (a_has_b) begin
                    res_anc_next = cur_reg;
                    res_dep_next = info_a_reg.depth;
                end else if (b_has_a) begin
                    res_anc_next = nb_reg;
                    res_dep_next = n_rdata.depth;
                end else begin
                    lvl_next = LVL_TOP;
                    j_re     = 1'b1;
                    j_raddr  = {cur_reg, LVL_TOP};
                end
            end
            ST_LIFT_UP: begin
                up_next = j_rdata;
                n_re    = 1'b1;
                n_raddr = j_rdata;
            end
            ST_LIFT_CMP: begin
                // advance to the candidate unless it already holds node b
                cur_next = lift_node;
                j_re     = 1'b1;
                if (lvl_reg == '0) begin
                    j_raddr = {lift_node, {LVL_W{1'b0}}};
                end else begin
                    lvl_next = lvl_reg - LVL_W'(1);
                    j_raddr  = {lift_node, lvl_reg - LVL_W'(1)};
                end
            end
            ST_FIN_J: begin
                res_anc_next = j_rdata;
                n_re         = 1'b1;
                n_raddr      = j_rdata;
            end
            ST_FIN_D: begin
                res_dep_next = n_rdata.depth;
            end
            ST_QRY_OUT: begin
                if (out_free) begin
                    m_tvalid_next   = 1'b1;
                    out_anc_next    = NODE_FIELD_W'(res_anc_reg);
                    out_dep_next    = res_dep_reg;
                    out_first_next  = info_a_reg.depth;
                    out_second_next = info_b_reg.depth;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            clock_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clock_reg    <= clock_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        op_reg         <= op_next;
        raw_a_reg      <= raw_a_next;
        raw_b_reg      <= raw_b_next;
        prod_a_reg     <= prod_a_next;
        prod_b_reg     <= prod_b_next;
        cur_reg        <= cur_next;
        nb_reg         <= nb_next;
        up_reg         <= up_next;
        lvl_reg        <= lvl_next;
        info_a_reg     <= info_a_next;
        info_b_reg     <= info_b_next;
        res_anc_reg    <= res_anc_next;
        res_dep_reg    <= res_dep_next;
        out_anc_reg    <= out_anc_next;
        out_dep_reg    <= out_dep_next;
        out_first_reg  <= out_first_next;
        out_second_reg <= out_second_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_second_reg, out_first_reg, out_dep_reg, out_anc_reg};

endmodule

### hdl/tlca_checker.sv
module tlca_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [tlca_pkg::M_TDATA_W-1:0] m_tdata
);
    import tlca_pkg::*;

    // hold a stalled result word
    a_m_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    a_m_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result word changed while stalled");

    // reset leaves no result pending
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // one word at a time: input closes right after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word taken while one is in work");

    // no result can appear the cycle after an accept
    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared without a query walk");

endmodule

bind tree_lca_binary_lifting tlca_checker u_tlca_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
